// File: src/uer_pkg.sv
package uer_pkg;

	// configuration register widths
	localparam int TRIG_W     = 16;
	localparam int TIMEOUT_W  = 24;
	localparam int SCALE_W    = 24;
	localparam int ALPHA_W    = 9;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 24;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_TICKS  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_DISTANCE_SCALE = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_ALPHA          = 2'd3;

	// reset values
	localparam logic [TRIG_W-1:0]    TRIGGER_RST = 16'd10;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd50000;
	localparam logic [SCALE_W-1:0]   SCALE_RST   = 24'd285213;
	localparam logic [ALPHA_W-1:0]   ALPHA_RST   = 9'd128;

	// fixed-point constants
	localparam int                 FRAC_BITS  = 16;
	localparam int                 AVG_SHIFT  = 8;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 9'd256;
	localparam int                 AVG_ROUND  = 128;

	// input and result field layout
	localparam int IN_W      = 2;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_FLAG_W = 4;

	typedef struct packed {
		logic load;    // take new operands
		logic clear;   // restart the accumulator
		logic round;   // start the accumulator at the rounding constant
	} uer_mac_ctl_t;

endpackage

// File: src/uer_mac.sv
module uer_mac #(
	parameter int ACC_W = 48,
	parameter int MUL_W = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  uer_pkg::uer_mac_ctl_t ctl,
	input  logic [ACC_W-1:0]    mcand,
	input  logic [MUL_W-1:0]    mplier,
	output logic                idle,
	output logic [ACC_W-1:0]    acc
);
	import uer_pkg::*;

	logic [ACC_W-1:0] mcand_q;
	logic [MUL_W-1:0] mplier_q;
	logic [ACC_W-1:0] acc_q;

	assign idle = (mplier_q == '0);
	assign acc  = acc_q;

	// shift-add: one multiplier bit per cycle, stops once no set bits remain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mplier_q <= '0;
			mcand_q  <= '0;
			acc_q    <= '0;
		end else if (ctl.load) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			if (ctl.clear) begin
				acc_q <= ctl.round ? ACC_W'(AVG_ROUND) : '0;
			end
		end else if (!idle) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[ACC_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MUL_W-1:1]};
		end
	end

endmodule

// File: src/ultrasonic_echo_ranger_ema_top.sv
// channel  | direction | transfer carries
// s_axis   | in        | one time-base tick: start_req, echo
// m_axis   | out       | one result per tick: flags, raw and smoothed distance
// cfg      | in        | register write, taken at once
//
// a tick that does not end a successful measurement loads the result register
// a successful end runs width*scale and the two average products through one
// shift-add unit, one multiplier bit per cycle, in states S_MUL, S_AVG1, S_AVG2
// and then S_OUT, which loads the result register
// arst_n clears phase, counter, distances and registers to their defaults
// input is held off during the products and while the result register is full
module ultrasonic_echo_ranger_ema_top #(
	parameter int COUNT_WIDTH = 24,
	parameter int DIST_WIDTH  = 18
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [uer_pkg::IN_TDATA_W-1:0]  s_tdata,  // start_req, echo
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// trigger, busy_res, done_res, timed_out, raw_distance, smoothed_distance
	output logic [((uer_pkg::OUT_FLAG_W + 2*DIST_WIDTH + 7)/8)*8-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [uer_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import uer_pkg::*;

	localparam int OUT_W   = OUT_FLAG_W + 2*DIST_WIDTH;
	localparam int TDATA_W = ((OUT_W + 7)/8)*8;
	localparam int LIM_W   = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
	localparam int ACC_A   = COUNT_WIDTH + SCALE_W;
	localparam int ACC_B   = DIST_WIDTH + ALPHA_W + 1;
	localparam int ACC_C   = FRAC_BITS + DIST_WIDTH + 1;
	localparam int ACC_AB  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
	localparam int ACC_W   = (ACC_AB > ACC_C) ? ACC_AB : ACC_C;
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_RISE, PH_HIGH} phase_t;
	typedef enum logic [2:0] {S_TICK, S_MUL, S_AVG1, S_AVG2, S_OUT} seq_t;

	logic [TRIG_W-1:0]      trig_q;
	logic [TIMEOUT_W-1:0]   timeout_q;
	logic [SCALE_W-1:0]     scale_q;
	logic [ALPHA_W-1:0]     alpha_q;

	phase_t                 phase_q, phase_nx;
	seq_t                   seq_q;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_nx, cnt_inc;
	logic [DIST_WIDTH-1:0]  raw_q, avg_q;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       out_q;

	logic                   start, echo, s_acc, out_free, out_load;
	logic                   done_nx, tout_nx, fin_ok;
	logic [ALPHA_W-1:0]     a_eff;
	logic [DIST_WIDTH-1:0]  d_sat, avg_new;

	uer_mac_ctl_t           mac_ctl;
	logic [ACC_W-1:0]       mac_mcand;
	logic [COUNT_WIDTH-1:0] mac_mplier;
	logic                   mac_idle;
	logic [ACC_W-1:0]       mac_acc;

	function automatic logic lim_hit(input logic [COUNT_WIDTH-1:0] c,
		input logic [TIMEOUT_W-1:0] t);
		// same as c >= min(t, counter max)
		lim_hit = (LIM_W'(c) >= LIM_W'(t)) || (c == CMAX);
	endfunction

	assign start    = s_tdata[0];
	assign echo     = s_tdata[1];
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (seq_q == S_TICK) && out_free;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_W'(out_q);
	assign out_load = (seq_q == S_TICK) ? (s_acc && !fin_ok)
		: ((seq_q == S_OUT) && out_free);

	assign cnt_inc = (cnt_q == CMAX) ? cnt_q : cnt_q + 1'b1;
	assign a_eff   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign d_sat   = (|mac_acc[ACC_W-1:FRAC_BITS+DIST_WIDTH]) ? '1
		: mac_acc[FRAC_BITS+DIST_WIDTH-1:FRAC_BITS];
	assign avg_new = mac_acc[AVG_SHIFT+DIST_WIDTH-1:AVG_SHIFT];

	// per-tick phase update
	always_comb begin
		phase_nx = phase_q;
		cnt_nx   = cnt_q;
		done_nx  = 1'b0;
		tout_nx  = 1'b0;
		fin_ok   = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					phase_nx = PH_TRIG;
					cnt_nx   = '0;
				end
			end
			PH_TRIG: begin
				cnt_nx = cnt_inc;
				if (cnt_inc >= COUNT_WIDTH'(trig_q)) begin
					phase_nx = PH_RISE;
					cnt_nx   = '0;
				end
			end
			PH_RISE: begin
				if (echo) begin
					phase_nx = PH_HIGH;
					cnt_nx   = COUNT_WIDTH'(1);
				end else begin
					cnt_nx = cnt_inc;
					if (lim_hit(cnt_inc, timeout_q)) begin
						done_nx = 1'b1;
						tout_nx = 1'b1;
					end
				end
			end
			default: begin
				if (!echo) begin
					done_nx = 1'b1;
					fin_ok  = 1'b1;
				end else if (lim_hit(cnt_q, timeout_q)) begin
					done_nx = 1'b1;
					tout_nx = 1'b1;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
		endcase
		if (done_nx) begin
			phase_nx = PH_IDLE;
			cnt_nx   = '0;
		end
	end

	// operand selection for the shared unit
	always_comb begin
		mac_ctl    = '0;
		mac_mcand  = ACC_W'(scale_q);
		mac_mplier = cnt_q;
		case (seq_q)
			S_TICK: begin
				if (s_acc && fin_ok) begin
					mac_ctl.load  = 1'b1;
					mac_ctl.clear = 1'b1;
				end
			end
			S_MUL: begin
				mac_mcand  = ACC_W'(d_sat);
				mac_mplier = COUNT_WIDTH'(a_eff);
				if (mac_idle) begin
					mac_ctl.load  = 1'b1;
					mac_ctl.clear = 1'b1;
					mac_ctl.round = 1'b1;
				end
			end
			S_AVG1: begin
				mac_mcand  = ACC_W'(avg_q);
				mac_mplier = COUNT_WIDTH'(ALPHA_ONE - a_eff);
				mac_ctl.load = mac_idle;
			end
			default: ;
		endcase
	end

	uer_mac #(
		.ACC_W (ACC_W),
		.MUL_W (COUNT_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.mcand  (mac_mcand),
		.mplier (mac_mplier),
		.idle   (mac_idle),
		.acc    (mac_acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q      <= TRIGGER_RST;
			timeout_q   <= TIMEOUT_RST;
			scale_q     <= SCALE_RST;
			alpha_q     <= ALPHA_RST;
			phase_q     <= PH_IDLE;
			seq_q       <= S_TICK;
			cnt_q       <= '0;
			raw_q       <= '0;
			avg_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_TRIGGER_TICKS:  trig_q    <= cfg_wdata[TRIG_W-1:0];
					REG_TIMEOUT_TICKS:  timeout_q <= cfg_wdata[TIMEOUT_W-1:0];
					REG_DISTANCE_SCALE: scale_q   <= cfg_wdata[SCALE_W-1:0];
					REG_ALPHA:          alpha_q   <= cfg_wdata[ALPHA_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (seq_q)
				S_TICK: begin
					if (s_acc) begin
						phase_q <= phase_nx;
						cnt_q   <= cnt_nx;
						if (fin_ok) begin
							seq_q <= S_MUL;
						end else begin
							out_q <= {avg_q, raw_q, tout_nx, done_nx,
								phase_nx != PH_IDLE, phase_nx == PH_TRIG};
						end
					end
				end
				S_MUL: begin
					if (mac_idle) begin
						raw_q <= d_sat;
						seq_q <= S_AVG1;
					end
				end
				S_AVG1: begin
					if (mac_idle) begin
						seq_q <= S_AVG2;
					end
				end
				S_AVG2: begin
					if (mac_idle) begin
						avg_q <= avg_new;
						seq_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_q <= {avg_q, raw_q, 1'b0, 1'b1, 1'b0, 1'b0};
						seq_q <= S_TICK;
					end
				end
				default: seq_q <= S_TICK;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// the shared unit has finished before a new tick can start it again
	a_mac_idle_at_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> mac_idle)
		else $error("shift-add unit still running while input is open");

	a_tout_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3]) |-> m_tdata[2])
		else $error("timeout flag without done");

	a_trigger_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[1] && !m_tdata[2]))
		else $error("trigger shown while not busy or on a done tick");

	// the echo width is at least one, so the product is always running
	a_finish_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && fin_ok) |=> (seq_q == S_MUL && !mac_idle))
		else $error("successful end did not start the distance product");
`endif

endmodule

// File: bench/tb_ultrasonic_echo_ranger_ema_top.sv
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_ema_top;
	import uer_pkg::*;

	localparam int COUNT_W    = 24;
	localparam int DIST_W     = 18;
	localparam int OUT_W      = ((OUT_FLAG_W + 2*DIST_W + 7)/8)*8;
	localparam int RAW_LSB    = OUT_FLAG_W;
	localparam int AVG_LSB    = OUT_FLAG_W + DIST_W;
	localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_W) - 1;
	localparam longint unsigned DIST_TOP  = (64'd1 << DIST_W) - 1;
	localparam int SETTLE     = COUNT_W + 40;
	localparam int CYCLE_CAP  = 1500000;

	typedef enum logic [1:0] {
		RNG_IDLE,
		RNG_TRIGGER,
		RNG_WAIT_RISE,
		RNG_COUNT_HIGH
	} ranger_phase_t;

	typedef struct {
		bit start;
		bit echo;
	} tick_t;

	typedef struct {
		bit              trigger;
		bit              busy;
		bit              done;
		bit              timed_out;
		logic [DIST_W-1:0] raw;
		logic [DIST_W-1:0] smooth;
	} ranger_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	ultrasonic_echo_ranger_ema_top #(
		.COUNT_WIDTH(COUNT_W),
		.DIST_WIDTH (DIST_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// predictor copy of the registers and state
	logic [TRIG_W-1:0]    cfg_trig  = TRIGGER_RST;
	logic [TIMEOUT_W-1:0] cfg_tmo   = TIMEOUT_RST;
	logic [SCALE_W-1:0]   cfg_scale = SCALE_RST;
	logic [ALPHA_W-1:0]   cfg_alpha = ALPHA_RST;

	ranger_phase_t   rng_phase = RNG_IDLE;
	longint unsigned rng_count = 0;
	longint unsigned rng_raw   = 0;
	longint unsigned rng_avg   = 0;

	tick_t          tick_q[$];
	ranger_report_t pending_reports[$];

	int  fail_count = 0;
	int  cycles = 0;
	int  stim_count = 0;
	bit  idle_on = 1'b1;
	bit  s_taken = 1'b0;
	int  src_gap = 0;
	int  snk_gap = 0;

	function automatic ranger_report_t ranger_tick(bit start, bit echo);
		longint unsigned lim, d, a, acc;
		bit done_f, tout_f;
		ranger_report_t r;
		done_f = 1'b0;
		tout_f = 1'b0;
		lim = (cfg_tmo > COUNT_TOP) ? COUNT_TOP : cfg_tmo;
		case (rng_phase)
			RNG_IDLE: begin
				if (start) begin
					rng_phase = RNG_TRIGGER;
					rng_count = 0;
				end
			end
			RNG_TRIGGER: begin
				if (rng_count < COUNT_TOP)
					rng_count++;
				if (rng_count >= cfg_trig) begin
					rng_phase = RNG_WAIT_RISE;
					rng_count = 0;
				end
			end
			RNG_WAIT_RISE: begin
				if (echo) begin
					rng_phase = RNG_COUNT_HIGH;
					rng_count = 1;
				end else begin
					if (rng_count < COUNT_TOP)
						rng_count++;
					if (rng_count >= lim) begin
						done_f = 1'b1;
						tout_f = 1'b1;
					end
				end
			end
			default: begin
				if (!echo) begin
					done_f = 1'b1;
					d = (rng_count * cfg_scale) >> FRAC_BITS;
					if (d > DIST_TOP)
						d = DIST_TOP;
					a = (cfg_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_alpha;
					acc = (a * d + (ALPHA_ONE - a) * rng_avg + AVG_ROUND) >> AVG_SHIFT;
					if (acc > DIST_TOP)
						acc = DIST_TOP;
					rng_raw = d;
					rng_avg = acc;
				end else if (rng_count >= lim) begin
					done_f = 1'b1;
					tout_f = 1'b1;
				end else begin
					rng_count++;
				end
			end
		endcase
		if (done_f) begin
			rng_phase = RNG_IDLE;
			rng_count = 0;
		end
		r.trigger   = (rng_phase == RNG_TRIGGER);
		r.busy      = (rng_phase != RNG_IDLE);
		r.done      = done_f;
		r.timed_out = tout_f;
		r.raw       = rng_raw[DIST_W-1:0];
		r.smooth    = rng_avg[DIST_W-1:0];
		return r;
	endfunction

	// tick driver
	always @(negedge clk) begin : tick_driver
		tick_t t;
		if (arst_n && (!s_tvalid || s_taken)) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (tick_q.size() > 0) begin
				t = tick_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {{(IN_TDATA_W-2){1'b0}}, t.echo, t.start};
				if (idle_on && $urandom_range(0, 7) == 0)
					src_gap <= $urandom_range(1, 11);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_gap > 0) begin
				m_tready <= 1'b0;
				snk_gap <= snk_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					snk_gap <= $urandom_range(1, 11);
			end
		end
	end

	// monitor: check results, predict on each accepted tick
	always @(posedge clk) begin : monitor
		ranger_report_t e;
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("CHECK FAILED");
			$finish;
		end
		s_taken = arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_tdata);
				fail_count++;
			end else begin
				e = pending_reports.pop_front();
				if (m_tdata[0] !== e.trigger) begin
					$error("trigger: expected %0d, got %0d", e.trigger, m_tdata[0]);
					fail_count++;
				end
				if (m_tdata[1] !== e.busy) begin
					$error("busy_res: expected %0d, got %0d", e.busy, m_tdata[1]);
					fail_count++;
				end
				if (m_tdata[2] !== e.done) begin
					$error("done_res: expected %0d, got %0d", e.done, m_tdata[2]);
					fail_count++;
				end
				if (m_tdata[3] !== e.timed_out) begin
					$error("timed_out: expected %0d, got %0d", e.timed_out, m_tdata[3]);
					fail_count++;
				end
				if (m_tdata[RAW_LSB +: DIST_W] !== e.raw) begin
					$error("raw_distance: expected %0d, got %0d", e.raw,
						m_tdata[RAW_LSB +: DIST_W]);
					fail_count++;
				end
				if (m_tdata[AVG_LSB +: DIST_W] !== e.smooth) begin
					$error("smoothed_distance: expected %0d, got %0d", e.smooth,
						m_tdata[AVG_LSB +: DIST_W]);
					fail_count++;
				end
			end
		end
		if (s_taken)
			pending_reports.push_back(ranger_tick(s_tdata[0], s_tdata[1]));
	end

	task automatic add_tick(bit start, bit echo);
		tick_t t;
		t.start = start;
		t.echo = echo;
		tick_q.push_back(t);
		stim_count++;
	endtask

	// start, trigger pulse, rise wait, echo width, falling edge
	task automatic add_measure(int rise_len, int width);
		add_tick(1'b1, 1'($urandom_range(0, 1)));
		repeat ((cfg_trig == 0) ? 1 : cfg_trig)
			add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		repeat (rise_len)
			add_tick($urandom_range(0, 3) == 0, 1'b0);
		repeat (width)
			add_tick($urandom_range(0, 3) == 0, 1'b1);
		add_tick($urandom_range(0, 3) == 0, 1'b0);
	endtask

	task automatic wait_drained();
		while (tick_q.size() != 0 || s_tvalid || pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_TRIGGER_TICKS:  cfg_trig = val[TRIG_W-1:0];
			REG_TIMEOUT_TICKS:  cfg_tmo = val[TIMEOUT_W-1:0];
			REG_DISTANCE_SCALE: cfg_scale = val[SCALE_W-1:0];
			REG_ALPHA:          cfg_alpha = val[ALPHA_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int trig, int tmo, int scale, int alph);
		wait_drained();
		write_reg(REG_TRIGGER_TICKS, CFG_DATA_W'(trig));
		write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(tmo));
		write_reg(REG_DISTANCE_SCALE, CFG_DATA_W'(scale));
		write_reg(REG_ALPHA, CFG_DATA_W'(alph));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int trig, int tmo, int scale, int alph, int n,
			int max_rise, int max_width, bit idle);
		int first;
		set_config(trig, tmo, scale, alph);
		idle_on = idle;
		first = stim_count;
		while (stim_count - first < n) begin
			if ($urandom_range(0, 9) < 8)
				add_measure($urandom_range(0, max_rise), $urandom_range(1, max_width));
			else
				repeat ($urandom_range(1, 6))
					add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: echo ignored when idle and on the start tick,
		// start ignored while busy, short clean measurement
		add_tick(1'b0, 1'b1);
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b1);
		repeat (10) add_tick(1'b1, 1'($urandom_range(0, 1)));
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b0);
		repeat (3) add_tick(1'b1, 1'b1);
		add_tick(1'b0, 1'b0);
		add_tick(1'b0, 1'b0);

		run_phase(10, 50000, 285213, 128, 90, 30, 60, 1'b1);
		run_phase(1, 40, 16777215, 256, 100, 45, 45, 1'b1);
		// zero trigger length, first with zero timeout and then with the smallest nonzero one
		run_phase(0, 0, $urandom_range(0, 16777215), $urandom_range(0, 256),
			60, 3, 3, 1'b1);
		run_phase(0, 1, $urandom_range(0, 16777215), $urandom_range(0, 256),
			50, 3, 3, 1'b1);
		run_phase($urandom_range(1, 20), $urandom_range(2, 30),
			$urandom_range(0, 16777215), $urandom_range(0, 511), 90, 32, 32, 1'b1);
		run_phase(3, 100, 0, 200, 70, 20, 40, 1'b0);

		// widest timeout and scale; one long echo saturates the distance
		set_config(2, 16777215, 16777215, 511);
		idle_on = 1'b1;
		add_measure(5, 1030);
		run_phase(2, 16777215, 16777215, 511, 80, 20, 60, 1'b1);

		run_phase($urandom_range(1, 8), $urandom_range(3, 25),
			$urandom_range(0, 16777215), 0, 80, 20, 25, 1'b1);
		run_phase($urandom_range(1, 12), $urandom_range(4, 40),
			$urandom_range(0, 16777215), $urandom_range(0, 300), 100, 30, 40, 1'b0);

		// longest trigger pulse, left running at the end
		set_config(65535, $urandom_range(1, 16777215), $urandom_range(0, 16777215),
			$urandom_range(0, 511));
		idle_on = 1'b0;
		add_tick(1'b1, 1'b0);
		repeat (40) add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

		wait_drained();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
